### rtl/igr_pkg.sv
// shared types, register codes and constants of the integer gelu requant core
package igr_pkg;

  localparam int NumStages = 7;
  localparam int CfgDataW  = 32;
  localparam int RegIdxW   = 3;
  localparam int XW        = 17;
  localparam int HW        = 17;
  localparam int SqW       = 15;

  typedef enum logic [RegIdxW-1:0] {
    REG_CLIP_BOUND      = 3'd0,
    REG_UNIT_VALUE      = 3'd1,
    REG_IN_OFFSET       = 3'd2,
    REG_OUT_OFFSET      = 3'd3,
    REG_RQ_MULTIPLIER   = 3'd4,
    REG_RQ_ADDEND       = 3'd5,
    REG_RQ_SHIFT_AMOUNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [7:0]  clip_bound;
    logic signed [15:0] unit_value;
    logic signed [15:0] in_offset;
    logic signed [15:0] out_offset;
    logic signed [31:0] rq_multiplier;
    logic signed [31:0] rq_addend;
    logic [4:0]         rq_shift_amount;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    clip_bound:      8'sd0,
    unit_value:      16'sd0,
    in_offset:       16'sd0,
    out_offset:      16'sd0,
    rq_multiplier:   32'sd1,
    rq_addend:       32'sd0,
    rq_shift_amount: 5'd0
  };

  localparam logic signed [31:0] SatHi = 32'sd127;
  localparam logic signed [31:0] SatLo = -32'sd128;

endpackage

### rtl/igr_in_if.sv
// input channel of the gelu core: one activation and its last flag per transfer
interface igr_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;
  logic              last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

### rtl/igr_out_if.sv
// output channel of the gelu core: one saturated result and its last flag per transfer
interface igr_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] activation;
  logic              last_out;

  modport source (output valid, output activation, output last_out, input ready);
  modport sink (input valid, input activation, input last_out, output ready);
endinterface

### rtl/int8_gelu_requant_core.sv
// top level of the integer gelu core with requantization
//
//   channel   dir  payload                        transfer when
//   samples   in   sample[7:0] s, last_in         valid && ready
//   results   out  activation[7:0] s, last_out    valid && ready
//   cfg       in   cfg_index[2:0], cfg_data[31:0] cfg_we
//
// seven register stages, one item per cycle while the results channel is not stalled
// synchronous active-high reset clears the valid bits and loads register defaults
// each stage holds while the one after it is full and stalled; empty stages still fill
// config writes take effect on the next cycle and apply to items in flight
module int8_gelu_requant_core
  import igr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  igr_in_if.sink              samples,
  igr_out_if.source           results
);

  cfg_t                  cfg;
  logic [NumStages:1]    valid;
  logic [NumStages:1]    last_pipe;
  logic [NumStages:1]    adv;
  logic signed [XW-1:0]  x;
  logic signed [HW-1:0]  h;
  logic signed [7:0]     act;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_BOUND:      cfg.clip_bound      <= cfg_data[7:0];
        REG_UNIT_VALUE:      cfg.unit_value      <= cfg_data[15:0];
        REG_IN_OFFSET:       cfg.in_offset       <= cfg_data[15:0];
        REG_OUT_OFFSET:      cfg.out_offset      <= cfg_data[15:0];
        REG_RQ_MULTIPLIER:   cfg.rq_multiplier   <= cfg_data[31:0];
        REG_RQ_ADDEND:       cfg.rq_addend       <= cfg_data[31:0];
        REG_RQ_SHIFT_AMOUNT: cfg.rq_shift_amount <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NumStages] = !valid[NumStages] || results.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[1]) begin
        valid[1] <= samples.valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      last_pipe[1] <= samples.last_in;
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (adv[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  igr_poly u_poly (
    .clk    (clk),
    .adv    (adv[3:1]),
    .cfg    (cfg),
    .sample (samples.sample),
    .x      (x),
    .h      (h)
  );

  igr_requant u_requant (
    .clk        (clk),
    .adv        (adv[7:4]),
    .cfg        (cfg),
    .x          (x),
    .h          (h),
    .activation (act)
  );

  assign samples.ready      = adv[1];
  assign results.valid      = valid[NumStages];
  assign results.activation = act;
  assign results.last_out   = last_pipe[NumStages];

  a_backpressure_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    !samples.ready |-> (results.valid && !results.ready)
  ) else $error("input stalled while output side is not stalled");

  a_ready_through: assert property (
    @(posedge clk) disable iff (rst)
    results.ready |-> samples.ready
  ) else $error("input not ready although output drains");

  a_empty_after_reset: assert property (
    @(posedge clk)
    $past(rst) |-> !results.valid
  ) else $error("result valid right after reset");

endmodule

### rtl/igr_poly.sv
// first three pipeline stages: input offset, clip, square term and gelu polynomial
module igr_poly
  import igr_pkg::*;
(
  input  logic                 clk,
  input  logic [2:0]           adv,
  input  cfg_t                 cfg,
  input  logic signed [7:0]    sample,
  output logic signed [XW-1:0] x,
  output logic signed [HW-1:0] h
);

  logic signed [XW-1:0]  s1_x;
  logic signed [XW-1:0]  s2_x;
  logic signed [XW-1:0]  s3_x;
  logic                  s2_pos;
  logic                  s2_neg;
  logic [SqW-1:0]        s2_sq;
  logic signed [HW-1:0]  s3_h;

  logic signed [XW-1:0]  x_sum;
  logic [XW-1:0]         x_abs;
  logic signed [8:0]     lim;
  logic                  use_lim;
  logic signed [9:0]     d;
  logic signed [19:0]    d_sq;
  logic signed [17:0]    unit_ext;
  logic signed [17:0]    t;
  logic signed [17:0]    poly;
  logic signed [17:0]    hsum;

  // stage 1: offset sample
  assign x_sum = $signed({{(XW-8){sample[7]}}, sample})
               + $signed({cfg.in_offset[15], cfg.in_offset});

  // stage 2: abs, clip and square
  always_comb begin
    x_abs   = s1_x[XW-1] ? unsigned'(-s1_x) : unsigned'(s1_x);
    lim     = 9'sd0 - $signed({cfg.clip_bound[7], cfg.clip_bound});
    use_lim = $signed({1'b0, x_abs}) > $signed({{(XW-8){lim[8]}}, lim});
    d       = use_lim ? 10'sd0
                      : $signed({1'b0, x_abs[8:0]})
                        + $signed({{2{cfg.clip_bound[7]}}, cfg.clip_bound});
    d_sq    = d * d;
  end

  // stage 3: polynomial and halved sum
  always_comb begin
    unit_ext = $signed({{2{cfg.unit_value[15]}}, cfg.unit_value});
    t        = unit_ext - $signed({3'b000, s2_sq});
    if (s2_pos) begin
      poly = t;
    end else if (s2_neg) begin
      poly = -t;
    end else begin
      poly = 18'sd0;
    end
    hsum = unit_ext + poly;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_x <= x_sum;
    end
    if (adv[1]) begin
      s2_x   <= s1_x;
      s2_pos <= !s1_x[XW-1] && (s1_x != '0);
      s2_neg <= s1_x[XW-1];
      s2_sq  <= d_sq[SqW-1:0];
    end
    if (adv[2]) begin
      s3_x <= s2_x;
      s3_h <= hsum[17:1];
    end
  end

  assign x = s3_x;
  assign h = s3_h;

endmodule

### rtl/igr_requant.sv
// last four pipeline stages: gelu product, requant multiply, addend and round, shift, out offset and saturate
module igr_requant
  import igr_pkg::*;
(
  input  logic                 clk,
  input  logic [3:0]           adv,
  input  cfg_t                 cfg,
  input  logic signed [XW-1:0] x,
  input  logic signed [HW-1:0] h,
  output logic signed [7:0]    activation
);

  logic signed [XW+HW-1:0] prod;
  logic [31:0]             s4_y;
  logic [31:0]             s5_p;
  logic [31:0]             s6_acc;
  logic signed [7:0]       act;

  logic [31:0]             p;
  logic [31:0]             rnd;
  logic [31:0]             acc;
  logic signed [31:0]      shr;
  logic signed [31:0]      res;
  logic signed [7:0]       sat;

  assign prod = x * h;

  always_comb begin
    p   = s4_y * unsigned'(cfg.rq_multiplier);
    rnd = (cfg.rq_shift_amount != 5'd0) ? (32'd1 << (cfg.rq_shift_amount - 5'd1)) : 32'd0;
    acc = s5_p + unsigned'(cfg.rq_addend) + rnd;
    shr = $signed(s6_acc) >>> cfg.rq_shift_amount;
    res = shr + $signed({{16{cfg.out_offset[15]}}, cfg.out_offset});
    if (res > SatHi) begin
      sat = SatHi[7:0];
    end else if (res < SatLo) begin
      sat = SatLo[7:0];
    end else begin
      sat = res[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s4_y <= prod[31:0];
    end
    if (adv[1]) begin
      s5_p <= p;
    end
    if (adv[2]) begin
      s6_acc <= acc;
    end
    if (adv[3]) begin
      act <= sat;
    end
  end

  assign activation = act;

endmodule

### sim/int8_gelu_requant_checker.sv
`timescale 1ns / 100ps
// scoreboard of the gelu core: mirrors the registers, predicts and checks each output transfer
module int8_gelu_requant_checker
  import igr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  igr_in_if                   in_ch,
  igr_out_if                  out_ch,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic signed [7:0] activation;
    logic              last_out;
  } gelu_out_t;

  cfg_t      regs_shadow;
  gelu_out_t pending_acts[$];

  function automatic gelu_out_t gelu_requant(input cfg_t c, input logic [7:0] s, input logic l);
    logic signed [31:0] smp, cb, uv, ofs_in, ofs_out, mul, add;
    logic signed [31:0] x, sgn, x_abs, lim, q, d, poly, y, acc;
    gelu_out_t r;
    smp     = {{24{s[7]}}, s};
    cb      = {{24{c.clip_bound[7]}}, c.clip_bound};
    uv      = {{16{c.unit_value[15]}}, c.unit_value};
    ofs_in  = {{16{c.in_offset[15]}}, c.in_offset};
    ofs_out = {{16{c.out_offset[15]}}, c.out_offset};
    mul     = c.rq_multiplier;
    add     = c.rq_addend;
    x = smp + ofs_in;
    if (x > 32'sd0) begin
      sgn = 32'sd1;
    end else if (x < 32'sd0) begin
      sgn = -32'sd1;
    end else begin
      sgn = 32'sd0;
    end
    x_abs = sgn * x;
    lim   = 32'sd0 - cb;
    q     = (x_abs > lim) ? lim : x_abs;
    d     = q + cb;
    poly  = sgn * (uv - d * d);
    y     = x * ((uv + poly) >>> 1);
    acc   = y * mul + add;
    // no rounding term on a zero shift
    if (c.rq_shift_amount != 5'd0) begin
      acc = acc + (32'sd1 <<< (c.rq_shift_amount - 5'd1));
    end
    acc = acc >>> c.rq_shift_amount;
    acc = acc + ofs_out;
    if (acc > SatHi) begin
      r.activation = SatHi[7:0];
    end else if (acc < SatLo) begin
      r.activation = SatLo[7:0];
    end else begin
      r.activation = acc[7:0];
    end
    r.last_out = l;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    gelu_out_t want;
    if (rst) begin
      regs_shadow = CfgReset;
      pending_acts.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_acts.size() == 0) begin
          $error("activation: transfer with nothing expected, got %0d",
                 $signed(out_ch.activation));
          fail_count++;
        end else begin
          want = pending_acts.pop_front();
          if (out_ch.activation !== want.activation) begin
            $error("activation: expected %0d, got %0d",
                   $signed(want.activation), $signed(out_ch.activation));
            fail_count++;
          end
          if (out_ch.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_ch.last_out);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_acts.push_back(gelu_requant(regs_shadow, in_ch.sample, in_ch.last_in));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CLIP_BOUND:      regs_shadow.clip_bound      = cfg_data[7:0];
          REG_UNIT_VALUE:      regs_shadow.unit_value      = cfg_data[15:0];
          REG_IN_OFFSET:       regs_shadow.in_offset       = cfg_data[15:0];
          REG_OUT_OFFSET:      regs_shadow.out_offset      = cfg_data[15:0];
          REG_RQ_MULTIPLIER:   regs_shadow.rq_multiplier   = cfg_data;
          REG_RQ_ADDEND:       regs_shadow.rq_addend       = cfg_data;
          REG_RQ_SHIFT_AMOUNT: regs_shadow.rq_shift_amount = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    pending <= pending_acts.size();
  end

endmodule

### sim/int8_gelu_requant_core_tb.sv
`timescale 1ns / 100ps
// top of the gelu core testbench: clock, reset, settings, samples, backpressure, verdict
module int8_gelu_requant_core_tb;
  import igr_pkg::*;

  localparam int QuietLimit = 2000;
  localparam logic [RegIdxW-1:0] RegSpare = 3'd7;
  localparam logic [7:0] EdgeSamples [8] = '{8'h80, 8'hbf, 8'hc0, 8'hff,
                                             8'h00, 8'h01, 8'h40, 8'h7f};

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [RegIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  gap_pct;
  int                  stall_pct;
  int                  quiet_cycles;

  igr_in_if  sample_ch ();
  igr_out_if result_ch ();

  int8_gelu_requant_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  int8_gelu_requant_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (sample_ch),
    .out_ch     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(input int cb, input int uv, input int io, input int oo,
                                    input logic [31:0] mul, input logic [31:0] add,
                                    input int sh);
    cfg_t c;
    c.clip_bound      = cb[7:0];
    c.unit_value      = uv[15:0];
    c.in_offset       = io[15:0];
    c.out_offset      = oo[15:0];
    c.rq_multiplier   = mul;
    c.rq_addend       = add;
    c.rq_shift_amount = sh[4:0];
    return c;
  endfunction

  function automatic cfg_t realistic_cfg();
    int b, u, m, sh;
    b = -int'($urandom_range(128, 1));
    u = b * b;
    u = $urandom_range((u * 2 > 32767) ? 32767 : u * 2, u / 2);
    m = $urandom_range(4095, 1);
    sh = $clog2(u) + $clog2(m) + int'($urandom_range(2, 0)) - 1;
    if (sh < 0) sh = 0;
    if (sh > 31) sh = 31;
    return make_cfg(b, u, int'($urandom_range(40, 0)) - 20, int'($urandom_range(40, 0)) - 20,
                    m, int'($urandom_range(4095, 0)) - 2048, sh);
  endfunction

  function automatic cfg_t wild_cfg();
    return make_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // upper data bits above a register's width carry noise
  task automatic load_settings(input cfg_t c, input bit poke_spare);
    logic [31:0] d;
    d = $urandom; d[7:0] = c.clip_bound;       write_reg(REG_CLIP_BOUND, d);
    d = $urandom; d[15:0] = c.unit_value;      write_reg(REG_UNIT_VALUE, d);
    d = $urandom; d[15:0] = c.in_offset;       write_reg(REG_IN_OFFSET, d);
    if (poke_spare) write_reg(RegSpare, $urandom);
    d = $urandom; d[15:0] = c.out_offset;      write_reg(REG_OUT_OFFSET, d);
    write_reg(REG_RQ_MULTIPLIER, c.rq_multiplier);
    write_reg(REG_RQ_ADDEND, c.rq_addend);
    d = $urandom; d[4:0] = c.rq_shift_amount;  write_reg(REG_RQ_SHIFT_AMOUNT, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic [7:0] s, input logic l);
    @(negedge clk);
    while ($urandom_range(99, 0) < gap_pct) begin
      sample_ch.valid   <= 1'b0;
      sample_ch.sample  <= 8'($urandom);
      sample_ch.last_in <= 1'($urandom);
      @(negedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.sample  <= s;
    sample_ch.last_in <= l;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic send_edges(input int step);
    for (int i = 0; i < 8; i += step) begin
      send_sample(EdgeSamples[i], (i + step >= 8));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 63; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 63; end
      default: begin gap_pct = 13; stall_pct = 13; end
    endcase
  endtask

  initial begin : stimulus
    cfg_t c;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    sample_ch.valid   = 1'b0;
    sample_ch.sample  = '0;
    sample_ch.last_in = 1'b0;
    gap_pct           = 0;
    stall_pct         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults, zero shift
    send_edges(3);
    settle();

    // typical polynomial: clip at 64, unit 4096
    load_settings(make_cfg(-64, 4096, 0, 0, 1, 0, 12), 1'b1);
    send_edges(1);
    settle();

    // positive clip bound
    load_settings(make_cfg(5, 100, 3, -2, 3, 7, 4), 1'b0);
    send_edges(3);
    settle();

    // wrapping products and sums
    load_settings(make_cfg(-128, 32767, 32767, 0, 32'h7fff_ffff, 32'h8000_0000, 31), 1'b0);
    send_edges(3);
    settle();

    // all registers at their minimum
    load_settings(make_cfg(-128, -32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000, 0),
                  1'b0);
    send_edges(3);
    settle();

    // all registers at their maximum
    load_settings(make_cfg(127, 32767, 32767, 32767, 32'h7fff_ffff, 32'h7fff_ffff, 31), 1'b1);
    send_edges(3);
    settle();

    for (int ph = 0; ph < 24; ph++) begin
      set_idling(ph % 4);
      if (ph % 3 == 2) begin
        c = wild_cfg();
      end else begin
        c = realistic_cfg();
      end
      if (ph % 8 == 5) c.rq_shift_amount = 5'd0;
      if (ph % 7 == 3) c.clip_bound = 8'($urandom_range(127, 0));
      load_settings(c, (ph % 5 == 0));
      repeat (40) send_sample(8'($urandom), ($urandom_range(7, 0) == 0));
      settle();
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/igr_pkg.sv
rtl/igr_in_if.sv
rtl/igr_out_if.sv
rtl/igr_poly.sv
rtl/igr_requant.sv
rtl/int8_gelu_requant_core.sv
sim/int8_gelu_requant_checker.sv
sim/int8_gelu_requant_core_tb.sv
